// File: sv/scaled_keyed_sprite_blit_macros.svh
// Assertion macros for the sprite blitter checker.
// Depends on nothing; expects clk_i and rst_ni in the including scope.
`ifndef SCALED_KEYED_SPRITE_BLIT_MACROS_SVH
`define SCALED_KEYED_SPRITE_BLIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SKSB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sksb: assertion failed");

// Next-cycle implication, disabled while in reset
`define SKSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sksb: assertion failed");

`endif

// File: sv/sksb_pkg.sv
// Shared types and constants of the sprite blitter.
// Depends on nothing; used by every RTL module of the block, but not by the interfaces.
package sksb_pkg;

  localparam int unsigned MaxScale = 8;
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned OpaqueBit = 24;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_DEST_X     = 3'd0;
  localparam logic [2:0] CFG_DEST_Y     = 3'd1;
  localparam logic [2:0] CFG_FB_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_FB_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_BMP_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_BMP_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_SCALE      = 3'd6;

  // Reset values of the registers
  localparam logic [12:0] RST_FB_WIDTH  = 13'd640;
  localparam logic [12:0] RST_FB_HEIGHT = 13'd480;
  localparam logic [12:0] RST_BMP_DIM   = 13'd1;
  localparam logic [3:0]  RST_SCALE     = 4'd1;

  localparam logic [12:0] DIM_MAX   = 13'(MaxDim);
  localparam logic [3:0]  SCALE_MAX = 4'(MaxScale);

  // Configuration after saturation, as the datapath sees it
  typedef struct packed {
    logic signed [12:0] dest_x;
    logic signed [12:0] dest_y;
    logic [12:0]        fw;
    logic [12:0]        fh;
    logic [12:0]        bw;
    logic [12:0]        bh;
    logic [3:0]         sc;
  } cfg_t;

  // One opaque block, already clipped to the framebuffer (inclusive bounds)
  typedef struct packed {
    logic [31:0] pix;
    logic [11:0] xs;
    logic [11:0] xe;
    logic [11:0] ys;
    logic [11:0] ye;
  } blk_t;

endpackage

// File: sv/sksb_pix_if.sv
// Input channel of the sprite blitter: one source pixel per request.
// Depends on nothing.
interface sksb_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

// File: sv/sksb_wr_if.sv
// Output channel of the sprite blitter: one framebuffer write per request.
// Depends on nothing.
interface sksb_wr_if;
  logic        valid;
  logic        ready;
  logic [23:0] write_addr;
  logic [31:0] pixel_data;
  logic        last_write;

  modport source (output valid, output write_addr, output pixel_data,
                  output last_write, input ready);
  modport sink   (input valid, input write_addr, input pixel_data,
                  input last_write, output ready);
endinterface

// File: sv/sksb_cfg.sv
// Configuration registers of the sprite blitter, with saturation of sizes.
// Depends on sksb_pkg.
module sksb_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [12:0]        cfg_data_i,
  output sksb_pkg::cfg_t     cfg_o
);

  logic [12:0] dest_x_q, dest_y_q, fb_width_q, fb_height_q, bmp_width_q, bmp_height_q;
  logic [3:0]  scale_q;

  // Register writes; unknown index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q     <= '0;
      dest_y_q     <= '0;
      fb_width_q   <= sksb_pkg::RST_FB_WIDTH;
      fb_height_q  <= sksb_pkg::RST_FB_HEIGHT;
      bmp_width_q  <= sksb_pkg::RST_BMP_DIM;
      bmp_height_q <= sksb_pkg::RST_BMP_DIM;
      scale_q      <= sksb_pkg::RST_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sksb_pkg::CFG_DEST_X:     dest_x_q     <= cfg_data_i;
        sksb_pkg::CFG_DEST_Y:     dest_y_q     <= cfg_data_i;
        sksb_pkg::CFG_FB_WIDTH:   fb_width_q   <= cfg_data_i;
        sksb_pkg::CFG_FB_HEIGHT:  fb_height_q  <= cfg_data_i;
        sksb_pkg::CFG_BMP_WIDTH:  bmp_width_q  <= cfg_data_i;
        sksb_pkg::CFG_BMP_HEIGHT: bmp_height_q <= cfg_data_i;
        sksb_pkg::CFG_SCALE:      scale_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Saturated view
  always_comb begin
    cfg_o.dest_x = $signed(dest_x_q);
    cfg_o.dest_y = $signed(dest_y_q);
    cfg_o.fw = (fb_width_q   > sksb_pkg::DIM_MAX) ? sksb_pkg::DIM_MAX : fb_width_q;
    cfg_o.fh = (fb_height_q  > sksb_pkg::DIM_MAX) ? sksb_pkg::DIM_MAX : fb_height_q;
    cfg_o.bw = (bmp_width_q  > sksb_pkg::DIM_MAX) ? sksb_pkg::DIM_MAX : bmp_width_q;
    cfg_o.bh = (bmp_height_q > sksb_pkg::DIM_MAX) ? sksb_pkg::DIM_MAX : bmp_height_q;
    if (scale_q == 4'd0) begin
      cfg_o.sc = 4'd1;
    end else if (scale_q > sksb_pkg::SCALE_MAX) begin
      cfg_o.sc = sksb_pkg::SCALE_MAX;
    end else begin
      cfg_o.sc = scale_q;
    end
  end

endmodule

// File: sv/sksb_front.sv
// Front end: accepts source pixels, tracks the bitmap position, places and
// clips each opaque block. Depends on sksb_pkg and sksb_pix_if.
module sksb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sksb_pkg::cfg_t     cfg_i,
  sksb_pix_if.sink           pix_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sksb_pkg::blk_t     blk_o
);

  logic [11:0]        col_q, row_q;
  logic               a_valid_q;
  logic [31:0]        a_pix_q;
  logic signed [16:0] a_x0_q, a_y0_q;

  logic               accept;
  logic               opaque;
  logic [15:0]        col_off, row_off;
  logic signed [16:0] x0_d, y0_d;
  logic signed [16:0] x_end, y_end, fw_s, fh_s, sc_s;
  logic               x_in, y_in;
  logic [12:0]        fw_m1, fh_m1;

  // The placement register drains whenever the queue has room
  assign pix_i.ready = !a_valid_q || !q_full_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign opaque      = pix_i.src_pixel[sksb_pkg::OpaqueBit];

  // Block origin: destination plus position times scale
  assign col_off = 16'(col_q) * 16'(cfg_i.sc);
  assign row_off = 16'(row_q) * 16'(cfg_i.sc);
  assign x0_d = 17'(cfg_i.dest_x) + $signed({1'b0, col_off});
  assign y0_d = 17'(cfg_i.dest_y) + $signed({1'b0, row_off});

  // Bitmap position counters, advancing on every request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (({1'b0, col_q} + 13'd1) >= cfg_i.bw) begin
        col_q <= '0;
        if (({1'b0, row_q} + 13'd1) >= cfg_i.bh) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 12'd1;
        end
      end else begin
        col_q <= col_q + 12'd1;
      end
    end
  end

  // Placement stage; transparent pixels are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept && opaque) begin
      a_valid_q <= 1'b1;
    end else if (!q_full_i) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && opaque) begin
      a_pix_q <= pix_i.src_pixel;
      a_x0_q  <= x0_d;
      a_y0_q  <= y0_d;
    end
  end

  // Clip stage: inclusive visible range of the block; an empty frame shows nothing
  assign fw_s  = $signed({4'b0, cfg_i.fw});
  assign fh_s  = $signed({4'b0, cfg_i.fh});
  assign sc_s  = $signed({13'b0, cfg_i.sc});
  assign x_end = a_x0_q + sc_s - 17'sd1;
  assign y_end = a_y0_q + sc_s - 17'sd1;
  assign x_in  = (cfg_i.fw != 13'd0) && (a_x0_q < fw_s) && (x_end >= 17'sd0);
  assign y_in  = (cfg_i.fh != 13'd0) && (a_y0_q < fh_s) && (y_end >= 17'sd0);
  assign fw_m1 = cfg_i.fw - 13'd1;
  assign fh_m1 = cfg_i.fh - 13'd1;

  always_comb begin
    blk_o.pix = a_pix_q;
    blk_o.xs  = (a_x0_q < 17'sd0) ? 12'd0 : a_x0_q[11:0];
    blk_o.ys  = (a_y0_q < 17'sd0) ? 12'd0 : a_y0_q[11:0];
    blk_o.xe  = (x_end >= fw_s) ? fw_m1[11:0] : x_end[11:0];
    blk_o.ye  = (y_end >= fh_s) ? fh_m1[11:0] : y_end[11:0];
  end

  // Fully clipped blocks never enter the queue
  assign push_o = a_valid_q && !q_full_i && x_in && y_in;

endmodule

// File: sv/sksb_queue.sv
// Short queue of clipped blocks between the front and back ends.
// Depends on sksb_pkg.
module sksb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sksb_pkg::blk_t     blk_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output sksb_pkg::blk_t     blk_o
);

  localparam int unsigned PtrW = $clog2(sksb_pkg::QDepth);

  sksb_pkg::blk_t mem_q [sksb_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(sksb_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign blk_o   = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= blk_i;
  end

endmodule

// File: sv/sksb_back.sv
// Back end: walks clipped blocks row by row; an output register emits
// one write per cycle while ready. Depends on sksb_pkg and sksb_wr_if.
module sksb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sksb_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  sksb_pkg::blk_t     q_blk_i,
  output logic               pop_o,
  sksb_wr_if.source          wr_o
);

  logic           busy_q;
  sksb_pkg::blk_t blk_q;
  logic [11:0]    cx_q, cy_q;
  logic           ov_q;
  logic [23:0]    addr_q;
  logic [31:0]    data_q;
  logic           last_q;

  logic           out_free, step, at_last;
  logic [24:0]    addr_full;

  assign out_free = !ov_q || wr_o.ready;
  assign step     = busy_q && out_free;
  assign at_last  = (cx_q == blk_q.xe) && (cy_q == blk_q.ye);
  assign pop_o    = q_valid_i && (!busy_q || (step && at_last));

  // Block walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
    end else if (step && at_last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      blk_q <= q_blk_i;
      cx_q  <= q_blk_i.xs;
      cy_q  <= q_blk_i.ys;
    end else if (step) begin
      if (cx_q == blk_q.xe) begin
        cx_q <= blk_q.xs;
        cy_q <= cy_q + 12'd1;
      end else begin
        cx_q <= cx_q + 12'd1;
      end
    end
  end

  // Linear address: row times pitch plus column
  assign addr_full = 25'(cy_q) * 25'(cfg_i.fw) + 25'(cx_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (step) begin
      ov_q <= 1'b1;
    end else if (wr_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      addr_q <= addr_full[23:0];
      data_q <= blk_q.pix;
      last_q <= at_last;
    end
  end

  assign wr_o.valid      = ov_q;
  assign wr_o.write_addr = addr_q;
  assign wr_o.pixel_data = data_q;
  assign wr_o.last_write = last_q;

endmodule

// File: sv/scaled_keyed_sprite_blit.sv
// Integer-scale sprite blitter with an alpha key: takes one source pixel per
// request and emits one framebuffer write per visible opaque block pixel.
// Depends on sksb_pkg, sksb_pix_if, sksb_wr_if, sksb_cfg, sksb_front,
// sksb_queue and sksb_back.
//
// Each source pixel (top displayed row first, left to right) is placed as a
// scale-by-scale block at dest + position*scale, clipped to the framebuffer,
// and written out row by row when bit 24 is set; last_write marks the final
// write of a pixel. The back end emits one write per cycle while the
// receiver is ready, so an opaque pixel with n visible block pixels gives n
// writes (up to 64 at scale 8); transparent or fully clipped pixels give
// none. The front end takes a pixel every cycle while the four-entry queue
// has room. Writes pass the placement, queue, walk and output registers.
// Registers must be written only while idle; the block does not enforce it.
module scaled_keyed_sprite_blit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  sksb_pix_if.sink    pix_i,
  sksb_wr_if.source   wr_o
);

  sksb_pkg::cfg_t cfg;
  sksb_pkg::blk_t push_blk, head_blk;
  logic           push, pop, q_full, q_valid;

  sksb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sksb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .push_o   (push),
    .blk_o    (push_blk)
  );

  sksb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .blk_i   (push_blk),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .blk_o   (head_blk)
  );

  sksb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_blk_i   (head_blk),
    .pop_o     (pop),
    .wr_o      (wr_o)
  );

endmodule

// File: sv/sksb_chk.sv
// Port-level checker for the sprite blitter, bound to the top level.
// Depends on scaled_keyed_sprite_blit_macros.svh and sksb_pkg.
`include "scaled_keyed_sprite_blit_macros.svh"

module sksb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        wr_valid_i,
  input logic        wr_ready_i,
  input logic [23:0] wr_addr_i,
  input logic [31:0] wr_data_i,
  input logic        wr_last_i
);

  // A stalled write keeps its request and payload
  `SKSB_ASSERT_NEXT(a_wr_hold, wr_valid_i && !wr_ready_i, wr_valid_i && $stable(wr_addr_i) && $stable(wr_data_i) && $stable(wr_last_i))

  // Only opaque pixels ever reach the framebuffer
  `SKSB_ASSERT_NOW(a_opaque_only, wr_valid_i, wr_data_i[sksb_pkg::OpaqueBit])

  // Writes inside one block all carry the same pixel word
  `SKSB_ASSERT_NEXT(a_block_data, wr_valid_i && wr_ready_i && !wr_last_i, !wr_valid_i || (wr_data_i == $past(wr_data_i)))

endmodule

bind scaled_keyed_sprite_blit sksb_chk u_sksb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .wr_valid_i (wr_o.valid),
  .wr_ready_i (wr_o.ready),
  .wr_addr_i  (wr_o.write_addr),
  .wr_data_i  (wr_o.pixel_data),
  .wr_last_i  (wr_o.last_write)
);

// File: tb/sv/scaled_keyed_sprite_blit_test.sv
// Self-checking testbench of scaled_keyed_sprite_blit: directed and random pixel
// streams with a mirror of the blitter that predicts every framebuffer write.
// Depends on sksb_pkg, sksb_pix_if, sksb_wr_if and the scaled_keyed_sprite_blit RTL.
module scaled_keyed_sprite_blit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  // Cycles to let the pipeline empty once no write is outstanding
  localparam int DrainCycles = 24;

  typedef struct {
    logic [23:0] addr;
    logic [31:0] data;
    logic        last;
  } fb_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [12:0] cfg_data;

  sksb_pix_if pix_if ();
  sksb_wr_if  wr_if ();

  scaled_keyed_sprite_blit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .wr_o       (wr_if)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the register file and the source position counters
  logic [12:0] reg_dest_x     = '0;
  logic [12:0] reg_dest_y     = '0;
  logic [12:0] reg_fb_width   = sksb_pkg::RST_FB_WIDTH;
  logic [12:0] reg_fb_height  = sksb_pkg::RST_FB_HEIGHT;
  logic [12:0] reg_bmp_width  = sksb_pkg::RST_BMP_DIM;
  logic [12:0] reg_bmp_height = sksb_pkg::RST_BMP_DIM;
  logic [3:0]  reg_scale      = sksb_pkg::RST_SCALE;
  logic [11:0] src_col_m      = '0;
  logic [11:0] src_row_m      = '0;

  fb_write_t pending_writes[$];

  int errors       = 0;
  int pixels_sent  = 0;
  int writes_seen  = 0;
  int reg_writes   = 0;
  int hold_len     = 0;
  bit no_idle      = 1'b0;

  function automatic int clamp_dim(logic [12:0] v);
    return (v > sksb_pkg::DIM_MAX) ? int'(sksb_pkg::DIM_MAX) : int'(v);
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Expected writes of one accepted pixel, then advance the source position
  task automatic predict_block_writes(input logic [31:0] pix);
    int s, fw, fh, bw, bh, x0, y0, rows, cols, k;
    fb_write_t w;
    s  = (reg_scale == 0) ? 1 :
         (reg_scale > sksb_pkg::SCALE_MAX) ? int'(sksb_pkg::SCALE_MAX) : int'(reg_scale);
    fw = clamp_dim(reg_fb_width);
    fh = clamp_dim(reg_fb_height);
    bw = clamp_dim(reg_bmp_width);
    bh = clamp_dim(reg_bmp_height);
    if (pix[sksb_pkg::OpaqueBit]) begin
      x0 = int'($signed(reg_dest_x)) + int'(src_col_m) * s;
      y0 = int'($signed(reg_dest_y)) + int'(src_row_m) * s;
      // visible part of the block is a rectangle; last write closes it
      rows = 0;
      cols = 0;
      for (int d = 0; d < s; d++) begin
        if (y0 + d >= 0 && y0 + d < fh) rows++;
        if (x0 + d >= 0 && x0 + d < fw) cols++;
      end
      k = 0;
      for (int dy = 0; dy < s; dy++) begin
        if (y0 + dy < 0 || y0 + dy >= fh) continue;
        for (int dx = 0; dx < s; dx++) begin
          if (x0 + dx < 0 || x0 + dx >= fw) continue;
          k++;
          w.addr = 24'((y0 + dy) * fw + x0 + dx);
          w.data = pix;
          w.last = (k == rows * cols);
          pending_writes.push_back(w);
        end
      end
    end
    // column wraps at the bitmap width, row at the bitmap height
    if (int'(src_col_m) + 1 >= bw) begin
      src_col_m = '0;
      if (int'(src_row_m) + 1 >= bh) src_row_m = '0;
      else src_row_m = src_row_m + 12'd1;
    end else begin
      src_col_m = src_col_m + 12'd1;
    end
    pixels_sent++;
  endtask

  // One register write; only called with nothing in flight
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      sksb_pkg::CFG_DEST_X:     reg_dest_x     = data;
      sksb_pkg::CFG_DEST_Y:     reg_dest_y     = data;
      sksb_pkg::CFG_FB_WIDTH:   reg_fb_width   = data;
      sksb_pkg::CFG_FB_HEIGHT:  reg_fb_height  = data;
      sksb_pkg::CFG_BMP_WIDTH:  reg_bmp_width  = data;
      sksb_pkg::CFG_BMP_HEIGHT: reg_bmp_height = data;
      sksb_pkg::CFG_SCALE:      reg_scale      = data[3:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [12:0] dx, input logic [12:0] dy,
                              input logic [12:0] fw, input logic [12:0] fh,
                              input logic [12:0] bw, input logic [12:0] bh,
                              input logic [12:0] sc);
    write_reg(sksb_pkg::CFG_DEST_X, dx);
    write_reg(sksb_pkg::CFG_DEST_Y, dy);
    write_reg(sksb_pkg::CFG_FB_WIDTH, fw);
    write_reg(sksb_pkg::CFG_FB_HEIGHT, fh);
    write_reg(sksb_pkg::CFG_BMP_WIDTH, bw);
    write_reg(sksb_pkg::CFG_BMP_HEIGHT, bh);
    write_reg(sksb_pkg::CFG_SCALE, sc);
  endtask

  // Offer one pixel request after a random gap and wait for its acceptance
  task automatic send_pixel(input logic [31:0] pix);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.src_pixel <= pix;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_block_writes(pix);
  endtask

  // Stop offering and let every expected write come out
  task automatic wait_drain();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] pix;
    pix = $urandom;
    pix[sksb_pkg::OpaqueBit] = ($urandom_range(0, 3) != 0);
    return pix;
  endfunction

  // Write receiver: random stalls, one long hold on request, field checks
  initial begin
    int stall;
    fb_write_t exp_w;
    wr_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_gap();
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        wr_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      wr_if.ready <= 1'b1;
      do @(posedge clk_i); while (!wr_if.valid);
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: addr %0h data %0h last %0b",
               wr_if.write_addr, wr_if.pixel_data, wr_if.last_write);
        errors++;
      end else begin
        exp_w = pending_writes.pop_front();
        if (wr_if.write_addr !== exp_w.addr) begin
          $error("write_addr: expected %0h, got %0h", exp_w.addr, wr_if.write_addr);
          errors++;
        end
        if (wr_if.pixel_data !== exp_w.data) begin
          $error("pixel_data: expected %0h, got %0h", exp_w.data, wr_if.pixel_data);
          errors++;
        end
        if (wr_if.last_write !== exp_w.last) begin
          $error("last_write: expected %0b, got %0b", exp_w.last, wr_if.last_write);
          errors++;
        end
      end
    end
  end

  // Reset values: 1x1 bitmap at the origin, scale 1
  task automatic test_reset_defaults();
    send_pixel(32'h0100_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFEFF_FFFF);
    wait_drain();
  endtask

  // Largest scale, scale zero taken as 1, scale above the limit saturated
  task automatic test_scale_limits();
    set_geometry(13'd0, 13'd0, 13'd4096, 13'd4096, 13'd2, 13'd1, 13'd8);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0123_4567);
    wait_drain();
    write_reg(sksb_pkg::CFG_SCALE, 13'd0);
    send_pixel(32'h01AB_CDEF);
    wait_drain();
    write_reg(sksb_pkg::CFG_SCALE, 13'd15);
    send_pixel(32'h8100_0001);
    wait_drain();
  endtask

  // Partial clipping on the left, top and bottom edges, then fully clipped extremes
  task automatic test_clipping();
    set_geometry(13'(-3), 13'(-2), 13'd5, 13'd5, 13'd2, 13'd2, 13'd4);
    send_pixel(32'h0111_1111);
    send_pixel(32'h0122_2222);
    send_pixel(32'h0133_3333);
    send_pixel(32'h0144_4444);
    wait_drain();
    set_geometry(13'(-4096), 13'd0, 13'd1, 13'd1, 13'd1, 13'd1, 13'd3);
    send_pixel(32'h0155_5555);
    wait_drain();
    write_reg(sksb_pkg::CFG_DEST_X, 13'd4095);
    write_reg(sksb_pkg::CFG_DEST_Y, 13'(-4096));
    send_pixel(32'h0166_6666);
    wait_drain();
  endtask

  // Zero and oversized dimensions, and a write to an unused index
  task automatic test_degenerate_sizes();
    set_geometry(13'd0, 13'd0, 13'd4, 13'd4, 13'd0, 13'd0, 13'd2);
    send_pixel(32'h0177_7777);
    send_pixel(32'h0188_8888);
    send_pixel(32'h0199_9999);
    wait_drain();
    write_reg(sksb_pkg::CFG_FB_WIDTH, 13'd0);
    send_pixel(32'h01AA_AAAA);
    wait_drain();
    set_geometry(13'd4095, 13'd4095, 13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8);
    send_pixel(32'h01BB_BBBB);
    send_pixel(32'h01CC_CCCC);
    wait_drain();
    set_geometry(13'd0, 13'd0, 13'd16, 13'd16, 13'd1, 13'd1, 13'd2);
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_pixel(32'h01DD_DDDD);
    wait_drain();
  endtask

  // Receiver holds off long while full-size blocks keep coming
  task automatic test_backpressure();
    set_geometry(13'd0, 13'd0, 13'd64, 13'd64, 13'd4, 13'd4, 13'd8);
    hold_len = 400;
    repeat (12) send_pixel(random_pixel() | 32'h0100_0000);
    wait_drain();
  endtask

  // Random geometries, each followed by a stream of random pixels
  task automatic test_random_sprites();
    int sc, fbw, fbh, bw, bh, dx, dy;
    for (int p = 0; p < 10; p++) begin
      sc  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                        : int'($urandom_range(1, 8));
      fbw = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(1, 48));
      fbh = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(1, 48));
      bw  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(1, 6));
      bh  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(1, 6));
      dx  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(0, 64)) - 24;
      dy  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191))
                                        : int'($urandom_range(0, 64)) - 24;
      set_geometry(13'(dx), 13'(dy), 13'(fbw), 13'(fbh), 13'(bw), 13'(bh), 13'(sc));
      // one phase runs back to back on both sides
      no_idle = (p == 4);
      repeat (40) send_pixel(random_pixel());
      wait_drain();
    end
    no_idle = 1'b0;
  endtask

  // Test sequence
  initial begin
    pix_if.valid     = 1'b0;
    pix_if.src_pixel = '0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_scale_limits();
    test_clipping();
    test_degenerate_sizes();
    test_backpressure();
    test_random_sprites();

    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      errors++;
    end
    $display("Run covered %0d source pixels, %0d framebuffer writes, %0d register writes,",
             pixels_sent, writes_seen, reg_writes);
    $display("including clipping, scale and size limits, and a long output stall.");
    if (errors == 0) begin
      $display("scaled_keyed_sprite_blit verification clean");
    end else begin
      $display("scaled_keyed_sprite_blit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("scaled_keyed_sprite_blit verification failed");
    $finish;
  end

endmodule

// File: scaled_keyed_sprite_blit.f
+incdir+sv
sv/sksb_pkg.sv
sv/sksb_pix_if.sv
sv/sksb_wr_if.sv
sv/sksb_cfg.sv
sv/sksb_front.sv
sv/sksb_queue.sv
sv/sksb_back.sv
sv/scaled_keyed_sprite_blit.sv
sv/sksb_chk.sv
tb/sv/scaled_keyed_sprite_blit_test.sv
